FILE: sv/fftr_pkg.sv
package fftr_pkg;

    // Header bytes below which a datagram is a runt
    localparam logic [10:0] HEADER_BYTES = 11'd12;

    // Result status codes
    localparam logic [2:0] ST_RUNT      = 3'd0;
    localparam logic [2:0] ST_STALE     = 3'd1;
    localparam logic [2:0] ST_STORED    = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;

    // One received packet header
    typedef struct packed {
        logic [10:0] packet_length;
        logic [31:0] frame_tag;
        logic [15:0] frag_idx;
        logic [15:0] frag_count;
    } fftr_in_t;

    // One tracking result
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_used;
        logic [5:0]  chunk_index;
        logic [6:0]  received_total;
        logic        frame_done;
        logic [31:0] done_frame;
        logic        evicted;
        logic [31:0] evicted_frame;
    } fftr_out_t;

endpackage

FILE: sv/frame_fragment_reassembly_tracker.sv
// Frame fragment reassembly tracker.
// s_ channel: one packet header word (length, frame id, packet index,
//   total packets) per handshake, valid/ready.
// m_ channel: exactly one result word per header: status, slot, chunk
//   index, received count, completion and eviction reports.
// Flow: an accepted header waits in the input register and is classified
//   when it moves on to the result register, where the window state and
//   the result register update together; that register drives m_data.
// Throughput: one word per cycle while the result drains. The slot match, victim pick and mask
//   update all sit in one pass between the input and result registers.
// Receiver stall: the result register holds its word while m_ready is
//   low; the input register still takes one more header, then s_ready
//   drops until the result drains.
// Reset (aresetn low, synchronous): all slots free, last completed frame
//   is zero, both registers empty. No clearing pass is needed.
module frame_fragment_reassembly_tracker #(
    parameter int SLOTS       = 5,
    parameter int MAX_PACKETS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fftr_pkg::fftr_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fftr_pkg::fftr_out_t m_data
);

    logic                in_valid_reg;
    fftr_pkg::fftr_in_t  in_data_reg;
    logic                out_valid_reg;
    fftr_pkg::fftr_out_t out_data_reg;
    fftr_pkg::fftr_out_t result;
    logic                out_free, fire;

    // Handshake
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    fftr_window #(
        .SLOTS       (SLOTS),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .result  (result)
    );

    // Register valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (fire) out_data_reg <= result;
    end

endmodule

FILE: sv/fftr_victim.sv
// Picks the slot holding the smallest frame id, lowest slot on a tie.
// All pairwise compares run in parallel, so the depth is one compare.
module fftr_victim #(
    parameter int SLOTS = 5
) (
    input  logic [SLOTS-1:0][31:0]                        frames,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  victim_idx
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] win;

    // A slot wins when it beats every lower slot strictly and every higher one or ties
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            win[i] = 1'b1;
            for (int j = 0; j < SLOTS; j++) begin
                if (j < i) begin
                    if (!(frames[i] < frames[j])) win[i] = 1'b0;
                end else if (j > i) begin
                    if (!(frames[i] <= frames[j])) win[i] = 1'b0;
                end
            end
        end
    end

    // Exactly one winner; encode it
    always_comb begin
        victim_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (win[i]) victim_idx = SLOT_W'(i);
        end
    end

endmodule

FILE: sv/fftr_window.sv
// Reassembly window: slot state plus the combinational update for one word.
module fftr_window #(
    parameter int SLOTS       = 5,
    parameter int MAX_PACKETS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  fftr_pkg::fftr_in_t  item,
    output fftr_pkg::fftr_out_t result
);

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXP_W     = $clog2(MAX_PACKETS + 1);
    localparam int MASK_BITS = ((MAX_PACKETS + 63) / 64) * 64;
    localparam int BIT_W     = $clog2(MASK_BITS);

    // Slot state
    logic [SLOTS-1:0]                 valid_reg, valid_next;
    logic [SLOTS-1:0][31:0]           frame_reg, frame_next;
    logic [SLOTS-1:0][EXP_W-1:0]      expected_reg, expected_next;
    logic [SLOTS-1:0][EXP_W-1:0]      count_reg, count_next;
    logic [SLOTS-1:0][MASK_BITS-1:0]  mask_reg, mask_next;
    logic [31:0]                      last_completed_reg, last_completed_next;

    // Decision signals
    logic                 hit, any_free;
    logic [SLOT_W-1:0]    hit_idx, free_idx, victim_idx, sel;
    logic                 runt, stale, too_many, take, alloc, evict;
    logic [EXP_W-1:0]     cur_expected, cur_count, new_count;
    logic [MASK_BITS-1:0] cur_mask, new_mask;
    logic [BIT_W-1:0]     bit_pos;
    logic                 out_range, dup, stored, done;

    fftr_victim #(
        .SLOTS (SLOTS)
    ) u_victim (
        .frames     (frame_reg),
        .victim_idx (victim_idx)
    );

    // Lookup of the frame id and of the lowest free slot
    always_comb begin
        hit      = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (valid_reg[k] && frame_reg[k] == item.frame_tag) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(k);
            end
            if (!valid_reg[k]) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    // Classification and the per-slot update
    always_comb begin
        runt     = item.packet_length < fftr_pkg::HEADER_BYTES;
        stale    = item.frame_tag < last_completed_reg;
        too_many = !hit && (item.frag_count > 16'(MAX_PACKETS));
        take     = !runt && !stale && !too_many;
        alloc    = take && !hit;
        evict    = alloc && !any_free;
        sel      = hit ? hit_idx : (any_free ? free_idx : victim_idx);

        cur_expected = alloc ? EXP_W'(item.frag_count) : expected_reg[sel];
        cur_count    = alloc ? '0 : count_reg[sel];
        cur_mask     = alloc ? '0 : mask_reg[sel];

        bit_pos   = item.frag_idx[BIT_W-1:0];
        out_range = item.frag_idx >= 16'(cur_expected);
        dup       = cur_mask[bit_pos];
        stored    = !out_range && !dup;

        new_count = cur_count + EXP_W'(stored);
        new_mask  = cur_mask;
        if (stored) new_mask[bit_pos] = 1'b1;
        done = take && (new_count == cur_expected);
    end

    // Result word
    always_comb begin
        result = '0;
        if (runt) begin
            result.status = fftr_pkg::ST_RUNT;
        end else if (stale) begin
            result.status = fftr_pkg::ST_STALE;
        end else if (too_many) begin
            result.status = fftr_pkg::ST_TOO_MANY;
        end else begin
            if (out_range) begin
                result.status = fftr_pkg::ST_RANGE;
            end else if (dup) begin
                result.status = fftr_pkg::ST_DUPLICATE;
            end else begin
                result.status      = fftr_pkg::ST_STORED;
                result.chunk_index = item.frag_idx[5:0];
            end
            result.slot_used      = 3'(sel);
            result.received_total = 7'(new_count);
        end
        if (done) begin
            result.frame_done = 1'b1;
            result.done_frame = item.frame_tag;
        end
        if (evict) begin
            result.evicted       = 1'b1;
            result.evicted_frame = frame_reg[victim_idx];
        end
    end

    // Next state
    always_comb begin
        valid_next          = valid_reg;
        frame_next          = frame_reg;
        expected_next       = expected_reg;
        count_next          = count_reg;
        mask_next           = mask_reg;
        last_completed_next = last_completed_reg;
        if (fire && take) begin
            valid_next[sel] = 1'b1;
            count_next[sel] = new_count;
            mask_next[sel]  = new_mask;
            if (alloc) begin
                frame_next[sel]    = item.frame_tag;
                expected_next[sel] = cur_expected;
            end
        end
        // Completion frees every slot at or below the finished id
        if (fire && done) begin
            last_completed_next = item.frame_tag;
            for (int k = 0; k < SLOTS; k++) begin
                if (frame_next[k] <= item.frame_tag) valid_next[k] = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= '0;
            last_completed_reg <= '0;
        end else begin
            valid_reg          <= valid_next;
            last_completed_reg <= last_completed_next;
        end
    end

    // Slot contents, read only while valid
    always_ff @(posedge aclk) begin
        frame_reg    <= frame_next;
        expected_reg <= expected_next;
        count_reg    <= count_next;
        mask_reg     <= mask_next;
    end

endmodule
